@@ sv/bbc_pkg.sv @@
// Shared types and codes of the block buffer cache.
`default_nettype none
package bbc_pkg;
  localparam int unsigned FuncW = 3;
  localparam int unsigned DevW = 8;
  localparam int unsigned BlockW = 32;
  localparam int unsigned SlotW = 4;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ReqW = 2;
  localparam int unsigned SectorW = 33;
  localparam int unsigned RefW = 8;

  localparam logic [FuncW-1:0] FN_GET = 3'd0;
  localparam logic [FuncW-1:0] FN_READ = 3'd1;
  localparam logic [FuncW-1:0] FN_WRITE = 3'd2;
  localparam logic [FuncW-1:0] FN_RELEASE = 3'd3;
  localparam logic [FuncW-1:0] FN_DIRTY = 3'd4;

  localparam logic [StatusW-1:0] ST_HIT = 3'd0;
  localparam logic [StatusW-1:0] ST_NEW = 3'd1;
  localparam logic [StatusW-1:0] ST_NONE_FREE = 3'd2;
  localparam logic [StatusW-1:0] ST_DONE = 3'd3;
  localparam logic [StatusW-1:0] ST_ERROR = 3'd4;

  localparam logic [ReqW-1:0] RQ_NONE = 2'd0;
  localparam logic [ReqW-1:0] RQ_READ = 2'd1;
  localparam logic [ReqW-1:0] RQ_WRITE = 2'd2;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [DevW-1:0] dev;
    logic [BlockW-1:0] block;
    logic [SlotW-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [SlotW-1:0] slot_out;
    logic [ReqW-1:0] request;
    logic [DevW-1:0] req_dev;
    logic [SectorW-1:0] req_sector;
    logic [RefW-1:0] ref_count;
    logic buffer_freed;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;     // capture the request
    logic search;   // one tag or free-order compare step
    logic shift;    // one free-order compaction step
    logic finish;   // apply the update and build the result
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic search_done;
    logic shift_done;
    logic need_shift;
  } sts_t;
endpackage
`default_nettype wire

@@ sv/bbc_if.sv @@
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface bbc_req_if;
  logic valid;
  logic ready;
  bbc_pkg::req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface bbc_rsp_if;
  logic valid;
  logic ready;
  bbc_pkg::rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/block_buffer_cache_unit.sv @@
// Top level of the block buffer cache: controller plus datapath.
//  channel  | dir | fields
//  req      | in  | func, dev, block, slot
//  rsp      | out | status, slot_out, request, req_dev, req_sector, ref_count, buffer_freed
// A request's time grows with each slot compared in the tag search and, on a hit, with each
// free-order entry scanned; the sequential tag and free-order walk sets this.
// Reset clears valid, dirty, count and allocation state at once; no clearing pass.
// A finished result waits in the output register; a new request is taken while it
// waits only once the controller is idle and the result register can be refilled.
`default_nettype none
module block_buffer_cache_unit #(
  parameter int unsigned NUM_BUFFERS = 16,
  parameter int unsigned SECTORS_PER_BLOCK = 2
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  bbc_req_if.sink req_i,
  bbc_rsp_if.source rsp_o
);
  import bbc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bbc_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(req_i.valid), .in_ready_o(req_i.ready),
    .out_valid_o(rsp_o.valid), .out_ready_i(rsp_o.ready),
    .cmd_o(cmd), .sts_i(sts)
  );

  bbc_dp #(.NUM_BUFFERS(NUM_BUFFERS), .SECTORS_PER_BLOCK(SECTORS_PER_BLOCK)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_i(req_i.data), .cmd_i(cmd), .sts_o(sts), .rsp_o(rsp_o.data)
  );
endmodule
`default_nettype wire

@@ sv/bbc_ctrl.sv @@
// Controller state machine of the block buffer cache.
`default_nettype none
module bbc_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output bbc_pkg::cmd_t cmd_o,
  input  wire bbc_pkg::sts_t sts_i
);
  import bbc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SRCH = 4'b0010,
    S_SHFT = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        cmd_o.search = 1'b1;
        if (sts_i.search_done) state_d = S_SHFT;
      end
      S_SHFT: begin
        if (sts_i.need_shift && !sts_i.shift_done) begin
          cmd_o.shift = 1'b1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        out_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule
`default_nettype wire

@@ sv/bbc_dp.sv @@
// Datapath of the block buffer cache: slot state, tag search and free order.
`default_nettype none
module bbc_dp #(
  parameter int unsigned NUM_BUFFERS = 16,
  parameter int unsigned SECTORS_PER_BLOCK = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire bbc_pkg::req_t req_i,
  input  wire bbc_pkg::cmd_t cmd_i,
  output bbc_pkg::sts_t sts_o,
  output bbc_pkg::rsp_t rsp_o
);
  import bbc_pkg::*;

  localparam int unsigned IdxW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int unsigned CntW = $clog2(NUM_BUFFERS + 1);

  logic [DevW-1:0] tag_dev_q [NUM_BUFFERS];
  logic [BlockW-1:0] tag_blk_q [NUM_BUFFERS];
  logic [IdxW-1:0] free_q [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] valid_q, dirty_q;
  logic [RefW-1:0] refs_q [NUM_BUFFERS];
  logic [CntW-1:0] alloc_q, flen_q;

  req_t req_q;
  logic [CntW-1:0] ptr_q;        // search index, then free-order index
  logic hit_q;
  logic [IdxW-1:0] hslot_q;      // hit slot
  logic fpos_found_q;            // hit slot located in free order
  logic [IdxW-1:0] fpos_q;
  logic phase_q;                 // 0: tag search, 1: free-order search
  rsp_t rsp_q, rsp_d;

  logic is_lookup;
  logic [IdxW-1:0] ptr_idx;
  assign is_lookup = (req_q.func == FN_GET) || (req_q.func == FN_READ);
  assign ptr_idx = ptr_q[IdxW-1:0];

  // The search walks slots for a tag hit, then the free order for the hit slot.
  assign sts_o.search_done = phase_q ? (ptr_q >= flen_q || fpos_found_q)
                                     : (!is_lookup || hit_q || ptr_q >= alloc_q);
  assign sts_o.need_shift = 1'b0;
  assign sts_o.shift_done = 1'b1;
  assign rsp_o = rsp_q;

  // Lookup decision.
  logic [IdxW-1:0] sel;
  logic [SlotW-1:0] s_in;
  logic s_ok;
  logic [IdxW-1:0] s_idx;
  logic [SectorW-1:0] sec;
  logic [SectorW-1:0] wsec;

  assign s_in = req_q.slot;
  assign s_ok = ({{(32-SlotW){1'b0}}, s_in} < 32'(alloc_q)) &&
                ({{(32-SlotW){1'b0}}, s_in} < NUM_BUFFERS);
  assign s_idx = IdxW'(s_in);
  assign sel = (alloc_q < CntW'(NUM_BUFFERS)) ? IdxW'(alloc_q) : free_q[0];

  always_comb begin
    sec = SectorW'(SectorW'(req_q.block) * SectorW'(SECTORS_PER_BLOCK));
    wsec = SectorW'(SectorW'(tag_blk_q[s_idx]) * SectorW'(SECTORS_PER_BLOCK));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      alloc_q <= '0;
      flen_q <= '0;
      for (int i = 0; i < NUM_BUFFERS; i++) refs_q[i] <= '0;
    end else if (cmd_i.finish) begin
      if (is_lookup) begin
        if (hit_q) begin
          if (refs_q[hslot_q] != '1) begin
            refs_q[hslot_q] <= refs_q[hslot_q] + 1'b1;
            if (fpos_found_q) begin
              for (int k = 0; k < NUM_BUFFERS; k++)
                if (k >= fpos_q && k + 1 < NUM_BUFFERS) free_q[k] <= free_q[k+1];
              flen_q <= flen_q - 1'b1;
            end
            if (req_q.func == FN_READ && !valid_q[hslot_q]) begin
              valid_q[hslot_q] <= 1'b1;
              dirty_q[hslot_q] <= 1'b0;
            end
          end
        end else if (alloc_q < CntW'(NUM_BUFFERS) || flen_q != '0) begin
          if (alloc_q < CntW'(NUM_BUFFERS)) begin
            alloc_q <= alloc_q + 1'b1;
          end else begin
            for (int k = 0; k + 1 < NUM_BUFFERS; k++) free_q[k] <= free_q[k+1];
            flen_q <= flen_q - 1'b1;
          end
          tag_dev_q[sel] <= req_q.dev;
          tag_blk_q[sel] <= req_q.block;
          refs_q[sel] <= RefW'(1);
          valid_q[sel] <= (req_q.func == FN_READ);
          dirty_q[sel] <= 1'b0;
        end
      end else if (req_q.func <= FN_DIRTY && s_ok) begin
        if (req_q.func == FN_DIRTY) begin
          if (refs_q[s_idx] != '0) dirty_q[s_idx] <= 1'b1;
        end else if (!(req_q.func == FN_RELEASE && refs_q[s_idx] == '0)) begin
          if (dirty_q[s_idx]) begin
            dirty_q[s_idx] <= 1'b0;
            valid_q[s_idx] <= 1'b1;
          end
          if (req_q.func == FN_RELEASE) begin
            refs_q[s_idx] <= refs_q[s_idx] - 1'b1;
            if (refs_q[s_idx] == RefW'(1) && flen_q < CntW'(NUM_BUFFERS)) begin
              free_q[flen_q[IdxW-1:0]] <= s_idx;
              flen_q <= flen_q + 1'b1;
            end
          end
        end
      end
    end
  end

  // Search sequencing and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      hit_q <= 1'b0;
      phase_q <= 1'b0;
      fpos_found_q <= 1'b0;
    end else if (cmd_i.load) begin
      ptr_q <= '0;
      hit_q <= 1'b0;
      phase_q <= 1'b0;
      fpos_found_q <= 1'b0;
    end else if (cmd_i.search) begin
      if (!phase_q) begin
        if (is_lookup && !hit_q && ptr_q < alloc_q &&
            tag_dev_q[ptr_idx] == req_q.dev && tag_blk_q[ptr_idx] == req_q.block) begin
          hit_q <= 1'b1;
          hslot_q <= ptr_idx;
          ptr_q <= '0;
          phase_q <= 1'b1;
        end else begin
          ptr_q <= ptr_q + 1'b1;
        end
      end else if (ptr_q < flen_q && !fpos_found_q) begin
        if (free_q[ptr_idx] == hslot_q) begin
          fpos_found_q <= 1'b1;
          fpos_q <= ptr_idx;
        end else begin
          ptr_q <= ptr_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp_d = '0;
    if (is_lookup) begin
      if (hit_q) begin
        rsp_d.slot_out = SlotW'(hslot_q);
        if (refs_q[hslot_q] == '1) begin
          rsp_d.status = ST_ERROR;
          rsp_d.ref_count = '1;
        end else begin
          rsp_d.status = ST_HIT;
          rsp_d.ref_count = refs_q[hslot_q] + 1'b1;
          if (req_q.func == FN_READ && !valid_q[hslot_q]) begin
            rsp_d.request = RQ_READ;
            rsp_d.req_dev = tag_dev_q[hslot_q];
            rsp_d.req_sector = SectorW'(SectorW'(tag_blk_q[hslot_q]) *
                                        SectorW'(SECTORS_PER_BLOCK));
          end
        end
      end else if (alloc_q < CntW'(NUM_BUFFERS) || flen_q != '0) begin
        rsp_d.status = ST_NEW;
        rsp_d.slot_out = SlotW'(sel);
        rsp_d.ref_count = RefW'(1);
        if (req_q.func == FN_READ) begin
          rsp_d.request = RQ_READ;
          rsp_d.req_dev = req_q.dev;
          rsp_d.req_sector = sec;
        end
      end else begin
        rsp_d.status = ST_NONE_FREE;
      end
    end else if (req_q.func > FN_DIRTY) begin
      rsp_d.status = ST_ERROR;
    end else if (!s_ok) begin
      rsp_d.status = ST_ERROR;
      rsp_d.slot_out = s_in;
    end else begin
      rsp_d.slot_out = s_in;
      if (req_q.func == FN_DIRTY) begin
        if (refs_q[s_idx] == '0) rsp_d.status = ST_ERROR;
        else begin
          rsp_d.status = ST_DONE;
          rsp_d.ref_count = refs_q[s_idx];
        end
      end else if (req_q.func == FN_RELEASE && refs_q[s_idx] == '0) begin
        rsp_d.status = ST_ERROR;
      end else begin
        rsp_d.status = ST_DONE;
        if (dirty_q[s_idx]) begin
          rsp_d.request = RQ_WRITE;
          rsp_d.req_dev = tag_dev_q[s_idx];
          rsp_d.req_sector = wsec;
        end
        if (req_q.func == FN_RELEASE) begin
          rsp_d.ref_count = refs_q[s_idx] - 1'b1;
          rsp_d.buffer_freed = (refs_q[s_idx] == RefW'(1)) &&
                               (flen_q < CntW'(NUM_BUFFERS));
        end else begin
          rsp_d.ref_count = refs_q[s_idx];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.finish) rsp_q <= rsp_d;
  end
endmodule
`default_nettype wire

@@ sv/bbc_checker.sv @@
// Port-level checker for the block buffer cache, bound to the top level.
`default_nettype none
module bbc_props (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire bbc_pkg::rsp_t out_data_i
);
  import bbc_pkg::*;

  a_no_accept_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i) else $error("back-to-back accept");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped");
  a_no_req_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status == ST_ERROR |-> out_data_i.request == RQ_NONE)
    else $error("request on error");
  a_freed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.buffer_freed |-> out_data_i.ref_count == '0)
    else $error("freed with nonzero count");
endmodule

bind block_buffer_cache_unit bbc_props u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(req_i.valid), .in_ready_i(req_i.ready),
  .out_valid_i(rsp_o.valid), .out_ready_i(rsp_o.ready), .out_data_i(rsp_o.data)
);
`default_nettype wire

@@ tb/bbc_checker.sv @@
// Checker for the block buffer cache: predicts each result and compares it.
`default_nettype none
module bbc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic req_valid_i,
  input wire logic req_ready_i,
  input wire bbc_pkg::req_t req_data_i,
  input wire logic rsp_valid_i,
  input wire logic rsp_ready_i,
  input wire bbc_pkg::rsp_t rsp_data_i,
  output int fail_count_o,
  output int pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bbc_pkg::*;

  localparam int NumBuf = 16;
  localparam int SecPerBlk = 2;

  logic [DevW-1:0] tag_dev [NumBuf];
  logic [BlockW-1:0] tag_blk [NumBuf];
  logic valid_q [NumBuf];
  logic dirty_q [NumBuf];
  logic [RefW-1:0] refs_q [NumBuf];
  int used_slots;
  int lru_q [$];
  rsp_t expected_rsp [$];

  function automatic rsp_t make_rsp(logic [StatusW-1:0] st, int s, logic [ReqW-1:0] rq,
                                    logic [DevW-1:0] d, logic [SectorW-1:0] sec,
                                    logic [RefW-1:0] rc, logic fr);
    rsp_t r;
    r.status = st; r.slot_out = s[SlotW-1:0]; r.request = rq; r.req_dev = d;
    r.req_sector = sec; r.ref_count = rc; r.buffer_freed = fr;
    return r;
  endfunction

  function automatic logic [SectorW-1:0] sector_of(logic [BlockW-1:0] b);
    logic [63:0] p;
    p = 64'(b) * SecPerBlk;
    return p[SectorW-1:0];
  endfunction

  function automatic rsp_t cache_step(req_t q);
    int s;
    bit hit;
    logic [StatusW-1:0] st;
    logic [ReqW-1:0] rq;
    logic [DevW-1:0] rd;
    logic [SectorW-1:0] rs;
    logic fr;
    s = 0; hit = 0; rq = RQ_NONE; rd = '0; rs = '0; fr = 1'b0;
    if (q.func == FN_GET || q.func == FN_READ) begin
      for (int i = 0; i < used_slots; i++) begin
        if (!hit && tag_dev[i] == q.dev && tag_blk[i] == q.block) begin
          s = i; hit = 1;
        end
      end
      if (hit) begin
        if (refs_q[s] == 8'hFF) return make_rsp(ST_ERROR, s, RQ_NONE, '0, '0, 8'hFF, 1'b0);
        foreach (lru_q[k]) if (lru_q[k] == s) begin lru_q.delete(k); break; end
        refs_q[s]++;
        st = ST_HIT;
      end else begin
        if (used_slots < NumBuf) begin
          s = used_slots++;
        end else if (lru_q.size() > 0) begin
          s = lru_q.pop_front();
        end else begin
          return make_rsp(ST_NONE_FREE, 0, RQ_NONE, '0, '0, '0, 1'b0);
        end
        tag_dev[s] = q.dev; tag_blk[s] = q.block;
        valid_q[s] = 0; dirty_q[s] = 0; refs_q[s] = 1;
        st = ST_NEW;
      end
      if (q.func == FN_READ && !valid_q[s]) begin
        valid_q[s] = 1; dirty_q[s] = 0;
        return make_rsp(st, s, RQ_READ, tag_dev[s], sector_of(tag_blk[s]), refs_q[s], 1'b0);
      end
      return make_rsp(st, s, RQ_NONE, '0, '0, refs_q[s], 1'b0);
    end
    if (q.func > FN_DIRTY) return make_rsp(ST_ERROR, 0, RQ_NONE, '0, '0, '0, 1'b0);
    s = int'(q.slot);
    if (s >= used_slots) return make_rsp(ST_ERROR, s, RQ_NONE, '0, '0, '0, 1'b0);
    if (q.func == FN_DIRTY) begin
      if (refs_q[s] == 0) return make_rsp(ST_ERROR, s, RQ_NONE, '0, '0, '0, 1'b0);
      dirty_q[s] = 1;
      return make_rsp(ST_DONE, s, RQ_NONE, '0, '0, refs_q[s], 1'b0);
    end
    if (q.func == FN_RELEASE && refs_q[s] == 0)
      return make_rsp(ST_ERROR, s, RQ_NONE, '0, '0, '0, 1'b0);
    if (dirty_q[s]) begin
      rq = RQ_WRITE; rd = tag_dev[s]; rs = sector_of(tag_blk[s]);
      dirty_q[s] = 0; valid_q[s] = 1;
    end
    if (q.func == FN_RELEASE) begin
      refs_q[s]--;
      if (refs_q[s] == 0 && lru_q.size() < NumBuf) begin
        lru_q.push_back(s); fr = 1'b1;
      end
    end
    return make_rsp(ST_DONE, s, rq, rd, rs, refs_q[s], fr);
  endfunction

  assign pending_o = expected_rsp.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e;
    if (!rst_ni) begin
      for (int i = 0; i < NumBuf; i++) begin
        valid_q[i] = 0; dirty_q[i] = 0; refs_q[i] = 0;
        tag_dev[i] = '0; tag_blk[i] = '0;
      end
      used_slots = 0;
      lru_q.delete();
      expected_rsp.delete();
      fail_count_o <= 0;
    end else begin
      // Check before predicting so a result never matches its own request.
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected result %p", $time, rsp_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_rsp.pop_front();
          if (e !== rsp_data_i) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (req_valid_i && req_ready_i) expected_rsp.push_back(cache_step(req_data_i));
    end
  end
endmodule
`default_nettype wire

@@ tb/tb_block_buffer_cache_unit.sv @@
// Testbench top of the block buffer cache: stimulus, reset and verdict.
`default_nettype none
module tb_block_buffer_cache_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bbc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int fail_count, pending, idle_cycles, sent;
  bit stall_on = 1'b0;

  bbc_req_if req_ch ();
  bbc_rsp_if rsp_ch ();

  block_buffer_cache_unit DUT (.clk_i, .rst_ni, .req_i(req_ch.sink), .rsp_o(rsp_ch.source));

  bbc_checker u_checker (
    .clk_i, .rst_ni,
    .req_valid_i(req_ch.valid), .req_ready_i(req_ch.ready), .req_data_i(req_ch.data),
    .rsp_valid_i(rsp_ch.valid), .rsp_ready_i(rsp_ch.ready), .rsp_data_i(rsp_ch.data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #6 clk_i = ~clk_i;

  // Receiver stalls in random runs, sometimes not at all for a long stretch.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 40) == 0) stall_on <= ~stall_on;
      rsp_ch.ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("block_buffer_cache_unit verification failed");
      $finish;
    end
  end

  task automatic send_req(logic [FuncW-1:0] f, logic [DevW-1:0] d, logic [BlockW-1:0] b,
                          logic [SlotW-1:0] s);
    req_ch.valid <= 1'b1;
    req_ch.data <= '{func: f, dev: d, block: b, slot: s};
    do @(posedge clk_i); while (!req_ch.ready);
    sent++;
  endtask

  task automatic idle_gap();
    int n;
    n = $urandom_range(1, 6);
    req_ch.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Mostly well-formed traffic on a small tag set so hits, reuse and eviction all occur.
  task automatic random_req();
    int r;
    logic [DevW-1:0] d;
    logic [BlockW-1:0] b;
    r = $urandom_range(0, 99);
    d = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
    b = ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 9));
    if ($urandom_range(0, 20) == 0) b = 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
    if (r < 30) send_req(FN_GET, d, b, 4'($urandom));
    else if (r < 55) send_req(FN_READ, d, b, 4'($urandom));
    else if (r < 65) send_req(FN_WRITE, d, b, 4'($urandom));
    else if (r < 85) send_req(FN_RELEASE, d, b, 4'($urandom));
    else if (r < 96) send_req(FN_DIRTY, d, b, 4'($urandom));
    else send_req(3'($urandom_range(5, 7)), d, b, 4'($urandom));
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: slots not in use, unknown funcs, field extremes.
    send_req(FN_WRITE, 8'h00, 32'h0, 4'd0);
    send_req(FN_RELEASE, 8'hFF, 32'hFFFF_FFFF, 4'd15);
    send_req(FN_DIRTY, 8'h00, 32'h0, 4'd3);
    send_req(3'd5, 8'hFF, 32'hFFFF_FFFF, 4'd15);
    send_req(3'd7, 8'h00, 32'h0, 4'd0);
    send_req(FN_READ, 8'hFF, 32'hFFFF_FFFF, 4'd0);  // largest block; sector still fits
    send_req(FN_GET, 8'h00, 32'h0, 4'd0);
    send_req(FN_READ, 8'h00, 32'h0, 4'd0);          // read of invalid hit slot
    send_req(FN_DIRTY, 8'h00, 32'h0, 4'd1);
    send_req(FN_WRITE, 8'h00, 32'h0, 4'd1);         // dirty write back
    send_req(FN_WRITE, 8'h00, 32'h0, 4'd1);         // clean write back
    send_req(FN_DIRTY, 8'h00, 32'h0, 4'd1);
    send_req(FN_RELEASE, 8'h00, 32'h0, 4'd1);
    send_req(FN_RELEASE, 8'h00, 32'h0, 4'd1);
    send_req(FN_RELEASE, 8'h00, 32'h0, 4'd1);       // release of a free slot
    send_req(FN_DIRTY, 8'h00, 32'h0, 4'd1);         // mark dirty on a free slot
    send_req(FN_GET, 8'h00, 32'h0, 4'd0);           // hit leaves the free order
    // Fill every slot, then miss with none free.
    for (int i = 2; i < 16; i++) send_req(FN_GET, 8'h5A, 32'(i), 4'd0);
    send_req(FN_GET, 8'hA5, 32'h1234_5678, 4'd0);
    req_ch.valid <= 1'b0;
    // Drive one slot to saturation.
    for (int i = 0; i < 256; i++) send_req(FN_GET, 8'h5A, 32'd2, 4'd0);
    for (int i = 0; i < 256; i++) send_req(FN_RELEASE, 8'h5A, 32'h0, 4'd2);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    for (int i = 0; i < 306; i++) begin
      random_req();
      if ($urandom_range(0, 7) == 0) idle_gap();
      if (i == 150) begin
        req_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk_i);
      end
    end
    req_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Ran %0d requests: directed corner cases, saturation, eviction,", sent);
    $display("and random get/read/write back/release/mark dirty traffic with stalls.");
    if (fail_count == 0) begin
      $display("block_buffer_cache_unit verification clean");
    end else begin
      $display("block_buffer_cache_unit verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
